// ----- design/slis_pkg.sv -----
// Shared constants, types and codes for the sorted list insert/search block.
package slis_pkg;

   localparam int CAPACITY = 32;
   localparam int KEY_BITS = 32;

   localparam int OP_BITS    = 2;
   localparam int ITEM_BITS  = 32;
   localparam int COUNT_BITS = 6;

   // Internal widths derived from capacity.
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int IDX_BITS = $clog2(CAPACITY);

   // Keys are kept masked to KEY_BITS; the field itself is 32 bits.
   localparam logic [ITEM_BITS-1:0] KEY_MASK =
      (KEY_BITS >= ITEM_BITS) ? {ITEM_BITS{1'b1}} :
      ITEM_BITS'((64'd1 << KEY_BITS) - 64'd1);

   typedef logic [OP_BITS-1:0]    op_code_type;
   typedef logic [ITEM_BITS-1:0]  item_type;
   typedef logic [COUNT_BITS-1:0] count_field_type;

   localparam op_code_type OP_INSERT = 2'd0;
   localparam op_code_type OP_LOOKUP = 2'd1;
   localparam op_code_type OP_CLEAR  = 2'd2;

   // Response status codes.
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_PUT,
      ST_LKP_SCAN,
      ST_EMIT
   } state_type;

endpackage

// ----- design/slis_if.sv -----
// Request and response channel interfaces for the sorted list block.
interface slis_req_if import slis_pkg::*; ();
   logic        valid;
   logic        ready;
   op_code_type operation;
   item_type    key;

   modport source (output valid, output operation, output key, input ready);
   modport sink   (input valid, input operation, input key, output ready);
endinterface

interface slis_rsp_if import slis_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            found;
   item_type        item_out;
   count_field_type entry_count;
   logic            list_full;
   logic            status;

   modport source (output valid, output found, output item_out, output entry_count,
                   output list_full, output status, input ready);
   modport sink   (input valid, input found, input item_out, input entry_count,
                   input list_full, input status, output ready);
endinterface

// ----- design/sorted_list_insert_search.sv -----
// Sorted insertion list: top level with sequencer, entry memory and response register.
// Clear, rejected insert, unused code and insert into an empty list go from idle
//   straight to the emit state; lookup scans from slot 0, insert shifts larger entries
//   up. One compare per cycle through the one-write, one-read entry memory.
// Throughput: one transaction at a time; req ready is high again once the result is
//   in the response register. Sync active-high reset empties the list, no clearing pass.
module sorted_list_insert_search import slis_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   slis_req_if.sink       req_bus,
   slis_rsp_if.source     rsp_bus
);

   localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_CAP = CNT_BITS'(CAPACITY);
   localparam logic [IDX_BITS-1:0] IDX_ONE = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] IDX_TWO = IDX_BITS'(2);

   // Sequencer state
   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;   // stored entries
   logic [IDX_BITS-1:0]  pos_ff, pos_in;       // insert gap / lookup index
   item_type             key_ff, key_in;       // masked probe key

   // Result held until the response register is free
   logic                 found_ff, found_in;
   item_type             item_ff, item_in;
   logic                 status_ff, status_in;

   // Response register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   item_type             rsp_item_ff;
   count_field_type      rsp_count_ff;
   logic                 rsp_full_ff;
   logic                 rsp_status_ff;
   logic                 rsp_load;

   // Entry memory: one write and one registered read per cycle
   item_type             entry_mem [CAPACITY];
   item_type             rd_data_ff;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   item_type             wr_data;
   logic [IDX_BITS-1:0]  rd_addr;

   item_type             req_key_masked;

   assign req_key_masked = req_bus.key & KEY_MASK;
   assign req_bus.ready  = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      item_ff   <= item_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      found_in  = found_ff;
      item_in   = item_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = key_ff;
      rd_addr   = pos_ff - IDX_ONE;
      rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               key_in    = req_key_masked;
               found_in  = 1'b0;
               item_in   = req_key_masked;
               status_in = STATUS_DONE;
               state_in  = ST_EMIT;
               unique case (req_bus.operation)
                  OP_INSERT: begin
                     if (count_ff >= CNT_CAP) begin
                        status_in = STATUS_FULL;    // full: list untouched
                     end else if (count_ff == '0) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = req_key_masked;
                        count_in = count_ff + CNT_ONE;
                     end else begin
                        // gap starts past the last entry; fetch the last entry
                        pos_in   = IDX_BITS'(count_ff);
                        rd_addr  = IDX_BITS'(count_ff - CNT_ONE);
                        state_in = ST_INS_SCAN;
                     end
                  end
                  OP_LOOKUP: begin
                     if (count_ff != '0) begin
                        pos_in   = '0;
                        rd_addr  = '0;
                        state_in = ST_LKP_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     item_in  = '0;
                  end
                  default: begin
                     // unused code: nothing changes
                  end
               endcase
            end
         end

         ST_INS_SCAN: begin
            // rd_data_ff holds entry[pos - 1]
            if (rd_data_ff > key_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data_ff;
               pos_in  = pos_ff - IDX_ONE;
               if (pos_ff == IDX_ONE) begin
                  state_in = ST_INS_PUT;        // gap reached slot 0
               end else begin
                  rd_addr = pos_ff - IDX_TWO;
               end
            end else begin
               // equal keys stay below, new key lands after them
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = key_ff;
               count_in = count_ff + CNT_ONE;
               state_in = ST_EMIT;
            end
         end

         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = key_ff;
            count_in = count_ff + CNT_ONE;
            state_in = ST_EMIT;
         end

         ST_LKP_SCAN: begin
            // rd_data_ff holds entry[pos]
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               item_in  = rd_data_ff;
               state_in = ST_EMIT;
            end else if ((CNT_BITS'(pos_ff) + CNT_ONE) == count_ff) begin
               state_in = ST_EMIT;              // miss
            end else begin
               pos_in  = pos_ff + IDX_ONE;
               rd_addr = pos_ff + IDX_ONE;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: count and full flag reflect the list after the op
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_found_ff  <= found_ff;
         rsp_item_ff   <= item_ff;
         rsp_count_ff  <= COUNT_BITS'(count_ff);
         rsp_full_ff   <= (count_ff == CNT_CAP);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.item_out    = rsp_item_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.list_full   = rsp_full_ff;
   assign rsp_bus.status      = rsp_status_ff;

endmodule

// ----- design/slis_checker.sv -----
// Port-level assertions for the sorted list block and their bind.
module slis_checker import slis_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_found,
   input item_type        rsp_item_out,
   input count_field_type rsp_entry_count,
   input logic            rsp_list_full,
   input logic            rsp_status
);

   // one transaction in flight: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction was in progress");

   // a rejected insert only happens on a full list and never reports a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_list_full && !rsp_found))
      else $error("rejected insert with list not full or with a hit");

   // a full list holds at least one entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_list_full) |-> (rsp_entry_count != '0 || CAPACITY > 63))
      else $error("full flag with empty count");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) &&
         $stable(rsp_item_out) && $stable(rsp_entry_count) &&
         $stable(rsp_list_full) && $stable(rsp_status)))
      else $error("response dropped or changed while stalled");

endmodule

bind sorted_list_insert_search slis_checker u_slis_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_found       (rsp_bus.found),
   .rsp_item_out    (rsp_bus.item_out),
   .rsp_entry_count (rsp_bus.entry_count),
   .rsp_list_full   (rsp_bus.list_full),
   .rsp_status      (rsp_bus.status)
);

// ----- tb/sv/tb_sorted_list_insert_search.sv -----
// Self-checking testbench for the sorted list block: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_sorted_list_insert_search;
   import slis_pkg::*;

   // Operation code that the block must ignore.
   localparam op_code_type OP_UNUSED = 2'd3;

   localparam int RANDOM_PER_PHASE = 440;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = CAPACITY + 10;
   localparam int REPORT_LIMIT     = 10;
   localparam int N_ROWS           = 25;

   // One response transaction, in port order.
   typedef struct packed {
      logic            found;
      item_type        item_out;
      count_field_type entry_count;
      logic            list_full;
      logic            status;
   } outcome_type;

   // One row of the directed plan. A row may repeat with a key step; pinned rows carry a
   // hand-written expected response, all others take the shadow list's answer.
   typedef struct {
      op_code_type op;
      item_type    key;
      int          repeat_n;
      int          key_step;
      bit          pinned;
      outcome_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   slis_req_if req_bus ();
   slis_rsp_if rsp_bus ();

   sorted_list_insert_search DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow copy of the list contents and count.
   item_type shadow_keys [CAPACITY];
   int       shadow_count;

   outcome_type  expected_outcomes [$];
   stim_row_type directed_plan [N_ROWS];

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int cycle_count;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the shadow list and return the response it should produce.
   function automatic outcome_type predict_list_op(input op_code_type op,
                                                   input item_type key_in);
      outcome_type o;
      item_type    k;
      int          pos;
      k             = key_in & KEY_MASK;
      o.found       = 1'b0;
      o.item_out    = k;
      o.status      = STATUS_DONE;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               o.status = STATUS_FULL;
            end else begin
               // Shift larger keys up; an equal key stays below the new one.
               pos = shadow_count;
               while (pos > 0 && shadow_keys[pos-1] > k) begin
                  shadow_keys[pos] = shadow_keys[pos-1];
                  pos--;
               end
               shadow_keys[pos] = k;
               shadow_count++;
            end
         end
         OP_LOOKUP: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_keys[i] == k) begin
                  o.found    = 1'b1;
                  o.item_out = shadow_keys[i];
                  break;
               end
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
            o.item_out   = '0;
         end
         default: ;
      endcase
      o.entry_count = count_field_type'(shadow_count);
      o.list_full   = (shadow_count == CAPACITY);
      return o;
   endfunction

   // Key mix: stored keys for lookups, a narrow range for duplicates, extremes, full random.
   function automatic item_type pick_key(input bit from_list);
      int sel;
      sel = $urandom_range(99);
      if (from_list && shadow_count > 0 && sel < 55)
         return shadow_keys[$urandom_range(shadow_count - 1)];
      sel = $urandom_range(99);
      if (sel < 35)
         return item_type'($urandom_range(15));
      if (sel < 45) begin
         case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return item_type'($urandom());
   endfunction

   // Present one request transaction. Entered and left at a falling edge.
   task automatic send_item(input op_code_type op, input item_type key,
                            input bit pinned, input outcome_type pinned_out);
      outcome_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.key       <= key;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      // Accepted: update the shadow list now, queue the expected response.
      predicted = predict_list_op(op, key);
      expected_outcomes.push_back(pinned ? pinned_out : predicted);
      @(negedge clock);
   endtask

   // Response side: random back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.found, rsp_bus.item_out, rsp_bus.entry_count,
                 rsp_bus.list_full, rsp_bus.status};
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: found=%0d item=%h count=%0d full=%0d status=%0d",
                        got.found, got.item_out, got.entry_count, got.list_full, got.status);
         end else begin
            want = expected_outcomes.pop_front();
            if (got.found !== want.found || got.item_out !== want.item_out ||
                got.entry_count !== want.entry_count || got.list_full !== want.list_full ||
                got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: exp found=%0d item=%h count=%0d full=%0d status=%0d",
                           want.found, want.item_out, want.entry_count, want.list_full,
                           want.status);
                  $display("          got found=%0d item=%h count=%0d full=%0d status=%0d",
                           got.found, got.item_out, got.entry_count, got.list_full,
                           got.status);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int       sel;
      op_code_type op;
      item_type key;

      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INSERT;
      req_bus.key       = '0;
      shadow_count      = 0;
      send_idle_pct     = 19;
      rsp_stall_pct     = 46;

      // Directed plan: empty list, unused code, extremes and duplicates, a descending fill
      // to capacity (every insert shifts the whole list), rejects when full, then an
      // ascending fill that runs one past capacity.
      directed_plan = '{
         '{OP_LOOKUP, 32'h0000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd0, 1'b0, STATUS_DONE}},
         '{OP_UNUSED, 32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b0, 32'hFFFF_FFFF, 6'd0, 1'b0, STATUS_DONE}},
         '{OP_CLEAR,  32'h5A5A_5A5A, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd0, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b0, 32'hFFFF_FFFF, 6'd1, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'h0000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd2, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'h0000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd3, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'h8000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h8000_0000, 6'd4, 1'b0, STATUS_DONE}},
         '{OP_LOOKUP, 32'h0000_0000, 1, 0, 1'b1,
           '{1'b1, 32'h0000_0000, 6'd4, 1'b0, STATUS_DONE}},
         '{OP_LOOKUP, 32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b1, 32'hFFFF_FFFF, 6'd4, 1'b0, STATUS_DONE}},
         '{OP_LOOKUP, 32'h1234_5678, 1, 0, 1'b1,
           '{1'b0, 32'h1234_5678, 6'd4, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'h7FFF_FFFF, 1, 0, 1'b0, '0},
         '{OP_INSERT, 32'h0000_0001, 1, 0, 1'b0, '0},
         '{OP_LOOKUP, 32'h7FFF_FFFF, 1, 0, 1'b0, '0},
         '{OP_CLEAR,  32'hC3C3_C3C3, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd0, 1'b0, STATUS_DONE}},
         // stale key after clear must miss
         '{OP_LOOKUP, 32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b0, 32'hFFFF_FFFF, 6'd0, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'hF000_0000, CAPACITY, -16777216, 1'b0, '0},
         '{OP_INSERT, 32'h0000_0005, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0005, 6'd32, 1'b1, STATUS_FULL}},
         '{OP_INSERT, 32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b0, 32'hFFFF_FFFF, 6'd32, 1'b1, STATUS_FULL}},
         '{OP_LOOKUP, 32'hE000_0000, 1, 0, 1'b0, '0},
         '{OP_LOOKUP, 32'hD100_0000, 1, 0, 1'b0, '0},
         '{OP_UNUSED, 32'h0000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd32, 1'b1, STATUS_DONE}},
         '{OP_CLEAR,  32'h0000_0000, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd0, 1'b0, STATUS_DONE}},
         '{OP_INSERT, 32'h0000_0001, CAPACITY + 1, 1, 1'b0, '0},
         '{OP_LOOKUP, 32'h0000_0020, 1, 0, 1'b0, '0},
         '{OP_CLEAR,  32'hFFFF_FFFF, 1, 0, 1'b1,
           '{1'b0, 32'h0000_0000, 6'd0, 1'b0, STATUS_DONE}}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 0: sender 19% idle, receiver 46% stall. Phase 1: swapped. Phase 2: none.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 19; rsp_stall_pct = 46; end
            1:       begin send_idle_pct = 46; rsp_stall_pct = 19; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase

         if (phase == 0) begin
            for (int r = 0; r < N_ROWS; r++)
               for (int i = 0; i < directed_plan[r].repeat_n; i++)
                  send_item(directed_plan[r].op,
                            item_type'(directed_plan[r].key + i * directed_plan[r].key_step),
                            directed_plan[r].pinned, directed_plan[r].want);
         end

         // Random traffic: insert-heavy so the list fills and overflows regularly,
         // rare clears, a trickle of the unused code.
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            sel = $urandom_range(999);
            if (sel < 520)
               op = OP_INSERT;
            else if (sel < 965)
               op = OP_LOOKUP;
            else if (sel < 980)
               op = OP_CLEAR;
            else
               op = OP_UNUSED;
            key = pick_key(op == OP_LOOKUP);
            send_item(op, key, 1'b0, '0);
         end

         // Hold off the sender until every outstanding response is back.
         req_bus.valid <= 1'b0;
         do @(negedge clock); while (expected_outcomes.size() != 0);
      end

      // Drain, then give the block time to emit anything stray.
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sorted_list_insert_search.f -----
design/slis_pkg.sv
design/slis_if.sv
design/sorted_list_insert_search.sv
design/slis_checker.sv
tb/sv/tb_sorted_list_insert_search.sv
